>>> hdl/kci_pkg.sv
// Shared types, constants and helpers of the keyframe curve interpolator.
`timescale 1ns / 1ps
package kci_pkg;

  typedef enum logic [2:0] {
    CMD_LINEAR  = 3'd0,
    CMD_HERMITE = 3'd1,
    CMD_BEZIER  = 3'd2,
    CMD_ACCEL   = 3'd3,
    CMD_DECEL   = 3'd4,
    CMD_HOLD    = 3'd5
  } cmd_e;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned ONE_Q24 = 16777216;
  localparam int unsigned BW      = 27;
  localparam int unsigned OPW     = 34;

  typedef struct packed {
    logic [2:0]         cmd;
    logic               flat;
    logic [16:0]        t;
    logic signed [31:0] lv;
    logic signed [31:0] rv;
    logic signed [31:0] sv;
    logic signed [31:0] ev;
    logic signed [33:0] slv;
    logic signed [33:0] erv;
    logic signed [35:0] tgt;
    logic signed [33:0] lkq;
    logic signed [33:0] sfk;
    logic signed [33:0] efk;
    logic signed [33:0] rkq;
    logic [23:0]        c;
    logic signed [31:0] res;
  } item_t;

  typedef struct packed {
    logic [3:0][BW-1:0] b;
  } bern_t;

  function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -40'sh0080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/kci_dot4.sv
// Pipelined four-term signed dot product: multiply, pair sum, total sum.
`timescale 1ns / 1ps
module kci_dot4 #(
  parameter int unsigned WW = 27,
  parameter int unsigned OW = 34
) (
  input  logic                 clk_i,
  input  logic signed [WW-1:0] w_i [4],
  input  logic signed [OW-1:0] x_i [4],
  output logic signed [63:0]   sum_o
);

  logic signed [WW+OW-1:0] prod_d [4];
  logic signed [WW+OW-1:0] prod_q [4];
  logic signed [63:0]      pair_q [2];
  logic signed [63:0]      sum_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = w_i[i] * x_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    pair_q[0] <= 64'(prod_q[0]) + 64'(prod_q[1]);
    pair_q[1] <= 64'(prod_q[2]) + 64'(prod_q[3]);
    sum_q     <= pair_q[0] + pair_q[1];
  end

  assign sum_o = sum_q;

endmodule

>>> hdl/kci_bern.sv
// Three-stage cubic Bernstein weights of a Q24 curve parameter.
`timescale 1ns / 1ps
module kci_bern (
  input  logic            clk_i,
  input  logic [23:0]     c_i,
  output kci_pkg::bern_t  bern_o
);

  function automatic logic [24:0] rnd24(input logic [49:0] p);
    logic [49:0] s;
    s = p + 50'(1 << 23);
    return s[48:24];
  endfunction

  logic [24:0] a_d;
  logic [24:0] a_q;
  logic [23:0] c_q;
  logic [49:0] aa_q, cc_q;
  logic [24:0] a2, c2;
  logic [49:0] a3r_q, ac_q, ca_q, c3r_q;
  logic [24:0] r1, r2;
  kci_pkg::bern_t bern_d, bern_q;

  assign a_d = 25'(kci_pkg::ONE_Q24) - {1'b0, c_i};
  assign a2  = rnd24(aa_q);
  assign c2  = rnd24(cc_q);
  assign r1  = rnd24(ac_q);
  assign r2  = rnd24(ca_q);

  always_comb begin
    bern_d.b[0] = kci_pkg::BW'(rnd24(a3r_q));
    bern_d.b[1] = kci_pkg::BW'(r1) + (kci_pkg::BW'(r1) << 1);
    bern_d.b[2] = kci_pkg::BW'(r2) + (kci_pkg::BW'(r2) << 1);
    bern_d.b[3] = kci_pkg::BW'(rnd24(c3r_q));
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    c_q    <= c_i;
    aa_q   <= a_d * a_d;
    cc_q   <= c_i * c_i;
    a3r_q  <= a2 * a_q;
    ac_q   <= a2 * c_q;
    ca_q   <= a_q * c2;
    c3r_q  <= c2 * c_q;
    bern_q <= bern_d;
  end

  assign bern_o = bern_q;

endmodule

>>> hdl/kci_poly.sv
// Linear, Hermite, acceleration and deceleration blends in a seven-stage pipeline.
`timescale 1ns / 1ps
module kci_poly (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  kci_pkg::item_t item_i,
  output logic           valid_o,
  output kci_pkg::item_t item_o
);

  localparam logic signed [19:0] One = 20'sd65536;

  logic [5:0]     vld_q;
  kci_pkg::item_t pipe_q [6];
  logic           vld_out_q;
  kci_pkg::item_t out_d;
  kci_pkg::item_t out_q;

  logic [16:0] u;
  logic [33:0] tt_q, uu_q, t3r_q;
  logic [33:0] tt_r, uu_r, t3_r;
  logic [16:0] t2_q, wdec_q;
  logic [16:0] t2_d, wdec_d;
  logic signed [19:0] ts, t2s, t3s, wds, wsel;
  logic signed [19:0] w_d [4];
  logic signed [19:0] w_q [4];
  logic signed [33:0] x_d [4];
  logic signed [33:0] x_q [4];
  logic signed [63:0] sum;
  logic signed [63:0] sum_r;
  logic               blend;

  assign u      = 17'(kci_pkg::ONE_Q16) - item_i.t;
  assign tt_r   = tt_q + 34'(1 << 15);
  assign uu_r   = uu_q + 34'(1 << 15);
  assign t2_d   = tt_r[32:16];
  assign wdec_d = 17'(kci_pkg::ONE_Q16) - uu_r[32:16];
  assign t3_r   = t3r_q + 34'(1 << 15);

  always_comb begin
    ts    = {3'b000, pipe_q[1].t};
    t2s   = {3'b000, t2_q};
    t3s   = {3'b000, t3_r[32:16]};
    wds   = {3'b000, wdec_q};
    blend = 1'b1;
    wsel  = ts;
    unique case (pipe_q[1].cmd)
      kci_pkg::CMD_LINEAR:  wsel = ts;
      kci_pkg::CMD_ACCEL:   wsel = t2s;
      kci_pkg::CMD_DECEL:   wsel = wds;
      kci_pkg::CMD_HERMITE: blend = 1'b0;
      default:              wsel = '0;
    endcase
    if (blend) begin
      w_d[0] = One - wsel;
      w_d[1] = wsel;
      w_d[2] = '0;
      w_d[3] = '0;
    end else begin
      w_d[0] = (t3s <<< 1) - (t2s + (t2s <<< 1)) + One;
      w_d[1] = (t2s + (t2s <<< 1)) - (t3s <<< 1);
      w_d[2] = t3s - (t2s <<< 1) + ts;
      w_d[3] = t3s - t2s;
    end
    x_d[0] = 34'(pipe_q[1].lv);
    x_d[1] = 34'(pipe_q[1].rv);
    x_d[2] = 34'(pipe_q[1].sv) - 34'(pipe_q[1].lv);
    x_d[3] = 34'(pipe_q[1].ev) - 34'(pipe_q[1].rv);
  end

  kci_dot4 #(.WW(20), .OW(34)) u_dot (
    .clk_i (clk_i),
    .w_i   (w_q),
    .x_i   (x_q),
    .sum_o (sum)
  );

  assign sum_r = sum + 64'sd32768;

  always_comb begin
    out_d     = pipe_q[5];
    out_d.res = kci_pkg::sat40(sum_r[55:16]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[4:0], valid_i};
      vld_out_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= item_i;
    for (int i = 1; i < 6; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
    tt_q   <= item_i.t * item_i.t;
    uu_q   <= u * u;
    t2_q   <= t2_d;
    wdec_q <= wdec_d;
    t3r_q  <= t2_d * pipe_q[0].t;
    w_q    <= w_d;
    x_q    <= x_d;
    out_q  <= out_d;
  end

  assign valid_o = vld_out_q;
  assign item_o  = out_q;

endmodule

>>> hdl/kci_step.sv
// One bisection step of the Bezier frame curve: weights, frame sum, compare and update.
`timescale 1ns / 1ps
module kci_step #(
  parameter int unsigned Step = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  kci_pkg::item_t item_i,
  output logic           valid_o,
  output kci_pkg::item_t item_o
);

  localparam int unsigned StepShift = 22 - Step;
  localparam logic [23:0] StepSize  = 24'(1) << StepShift;

  logic [5:0]     vld_q;
  kci_pkg::item_t pipe_q [6];
  logic           vld_out_q;
  kci_pkg::item_t out_d;
  kci_pkg::item_t out_q;
  kci_pkg::bern_t bern;
  logic signed [kci_pkg::BW-1:0]  w [4];
  logic signed [kci_pkg::OPW-1:0] x [4];
  logic signed [63:0] xsum;
  logic signed [63:0] tgt64;
  logic [23:0]        c_d;

  kci_bern u_bern (
    .clk_i  (clk_i),
    .c_i    (item_i.c),
    .bern_o (bern)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = $signed(bern.b[i]);
    end
    x[0] = pipe_q[2].lkq;
    x[1] = pipe_q[2].sfk;
    x[2] = pipe_q[2].efk;
    x[3] = pipe_q[2].rkq;
  end

  kci_dot4 #(.WW(kci_pkg::BW), .OW(kci_pkg::OPW)) u_dot (
    .clk_i (clk_i),
    .w_i   (w),
    .x_i   (x),
    .sum_o (xsum)
  );

  assign tgt64 = {{4{pipe_q[5].tgt[35]}}, pipe_q[5].tgt, 24'h000000};
  assign c_d   = (tgt64 < xsum) ? pipe_q[5].c - StepSize : pipe_q[5].c + StepSize;

  always_comb begin
    out_d   = pipe_q[5];
    out_d.c = c_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[4:0], valid_i};
      vld_out_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= item_i;
    for (int i = 1; i < 6; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
    out_q <= out_d;
  end

  assign valid_o = vld_out_q;
  assign item_o  = out_q;

endmodule

>>> hdl/kci_final.sv
// Bezier value curve at the found parameter and the per-command result select.
`timescale 1ns / 1ps
module kci_final (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  kci_pkg::item_t     item_i,
  output logic               valid_o,
  output logic signed [31:0] value_o
);

  logic [5:0]     vld_q;
  kci_pkg::item_t pipe_q [6];
  logic           vld_out_q;
  logic signed [31:0] value_q;
  logic signed [31:0] value_d;
  kci_pkg::bern_t bern;
  logic signed [kci_pkg::BW-1:0]  w [4];
  logic signed [kci_pkg::OPW-1:0] x [4];
  logic signed [63:0] vsum;
  logic signed [63:0] vsum_r;

  kci_bern u_bern (
    .clk_i  (clk_i),
    .c_i    (item_i.c),
    .bern_o (bern)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = $signed(bern.b[i]);
    end
    x[0] = 34'(pipe_q[2].lv);
    x[1] = pipe_q[2].slv;
    x[2] = pipe_q[2].erv;
    x[3] = 34'(pipe_q[2].rv);
  end

  kci_dot4 #(.WW(kci_pkg::BW), .OW(kci_pkg::OPW)) u_dot (
    .clk_i (clk_i),
    .w_i   (w),
    .x_i   (x),
    .sum_o (vsum)
  );

  assign vsum_r = vsum + 64'sd8388608;

  always_comb begin
    if (pipe_q[5].cmd != kci_pkg::CMD_BEZIER) begin
      value_d = pipe_q[5].res;
    end else if (pipe_q[5].flat) begin
      value_d = pipe_q[5].lv;
    end else begin
      value_d = kci_pkg::sat40(vsum_r[63:24]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[4:0], valid_i};
      vld_out_q <= vld_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= item_i;
    for (int i = 1; i < 6; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
    value_q <= value_d;
  end

  assign valid_o = vld_out_q;
  assign value_o = value_q;

endmodule

>>> hdl/keyframe_curve_interpolator_unit.sv
// Top level of the keyframe curve interpolator pipeline.
`timescale 1ns / 1ps
// The unit takes one beat in every clock cycle and busy_o is never raised, so
// start_i may be held high continuously. Each beat leaves on done_o, with its
// value on interpolated_value_o, in order, after passing the input register,
// the blend pipeline and the Bezier parameter search. Every bisection step of
// that search is a seven-stage section of Bernstein weight multipliers, a
// four-term product sum and a compare, followed by one more such section that
// evaluates the value curve. The result is shown for a single cycle and
// cannot be held off.
module keyframe_curve_interpolator_unit #(
  parameter int unsigned BISECTION_STEPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic [16:0]        rate_i,
  input  logic signed [31:0] left_value_i,
  input  logic signed [31:0] right_value_i,
  input  logic signed [31:0] curve_start_value_i,
  input  logic signed [31:0] curve_end_value_i,
  input  logic signed [31:0] curve_start_frame_i,
  input  logic signed [31:0] curve_end_frame_i,
  input  logic [15:0]        left_key_frame_i,
  input  logic [15:0]        right_key_frame_i,
  output logic               done_o,
  output logic signed [31:0] interpolated_value_o
);

  kci_pkg::item_t item_d;
  kci_pkg::item_t item_q;
  logic           vld_q;
  logic [16:0]    t_sat;
  logic signed [16:0] dk;
  logic signed [17:0] ts;
  logic signed [35:0] lk36;
  logic signed [33:0] lkq, rkq;

  logic           poly_vld;
  kci_pkg::item_t poly_item;
  logic           chain_vld [BISECTION_STEPS+1];
  kci_pkg::item_t chain_itm [BISECTION_STEPS+1];

  assign busy_o = 1'b0;
  assign t_sat  = (rate_i > 17'(kci_pkg::ONE_Q16)) ? 17'(kci_pkg::ONE_Q16) : rate_i;
  assign dk     = $signed({1'b0, right_key_frame_i}) - $signed({1'b0, left_key_frame_i});
  assign ts     = {1'b0, t_sat};
  assign lk36   = {4'h0, left_key_frame_i, 16'h0000};
  assign lkq    = {2'b00, left_key_frame_i, 16'h0000};
  assign rkq    = {2'b00, right_key_frame_i, 16'h0000};

  always_comb begin
    item_d.cmd  = command_i;
    item_d.flat = (left_value_i == right_value_i) && (curve_start_value_i == '0)
                  && (curve_end_value_i == '0);
    item_d.t    = t_sat;
    item_d.lv   = left_value_i;
    item_d.rv   = right_value_i;
    item_d.sv   = curve_start_value_i;
    item_d.ev   = curve_end_value_i;
    item_d.slv  = 34'(curve_start_value_i) + 34'(left_value_i);
    item_d.erv  = 34'(curve_end_value_i) + 34'(right_value_i);
    item_d.tgt  = dk * ts + lk36;
    item_d.lkq  = lkq;
    item_d.sfk  = 34'(curve_start_frame_i) + lkq;
    item_d.efk  = 34'(curve_end_frame_i) + rkq;
    item_d.rkq  = rkq;
    item_d.c    = 24'(kci_pkg::ONE_Q24 / 2);
    item_d.res  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  kci_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q),
    .item_i  (item_q),
    .valid_o (poly_vld),
    .item_o  (poly_item)
  );

  assign chain_vld[0] = poly_vld;
  assign chain_itm[0] = poly_item;

  for (genvar g = 0; g < BISECTION_STEPS; g++) begin : g_step
    kci_step #(.Step(g)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_vld[g]),
      .item_i  (chain_itm[g]),
      .valid_o (chain_vld[g+1]),
      .item_o  (chain_itm[g+1])
    );
  end

  kci_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_vld[BISECTION_STEPS]),
    .item_i  (chain_itm[BISECTION_STEPS]),
    .valid_o (done_o),
    .value_o (interpolated_value_o)
  );

endmodule
